@@ hw/rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// BER-TLV stream parser package
// Shared types and constants: parse phases, byte roles, error codes, queue
// and result words.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [4:0] TAG_MORE_BITS = 5'h1F;
   localparam logic [7:0] LEN_ONE_BYTE  = 8'h81;
   localparam logic [7:0] LEN_TWO_BYTES = 8'h82;

   typedef enum logic [6:0] {
      PH_TAG1  = 7'b0000001,
      PH_TAG2  = 7'b0000010,
      PH_TAG3  = 7'b0000100,
      PH_LEN1  = 7'b0001000,
      PH_LENX  = 7'b0010000,
      PH_VALUE = 7'b0100000,
      PH_ERROR = 7'b1000000
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_TAG = 2'd0,
      ROLE_LEN = 2'd1,
      ROLE_VAL = 2'd2,
      ROLE_IGN = 2'd3
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_BAD_TAG  = 3'd1,
      ERR_BAD_LEN  = 3'd2,
      ERR_OVERRUN  = 3'd3,
      ERR_EMPTY    = 3'd4,
      ERR_TOO_DEEP = 3'd5
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       tag_more;
      logic       hi_bit;
      logic       cons_bit;
      logic       len_long;
   } q_word_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      role_type    byte_role;
      logic [23:0] tag_value;
      logic [15:0] value_length;
      logic        is_constructed;
      logic [3:0]  nest_depth;
      logic        header_done;
      logic        reported;
      logic        item_end;
      err_type     error_code;
      logic        structure_done;
   } rsp_word_type;

endpackage

@@ hw/rtl/bts_req_if.sv @@
// ----------------------------------------------------------------------------
// BER-TLV request channel
// Valid/ready channel carrying one structure byte and its last flag.
// ----------------------------------------------------------------------------
interface bts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_structure;

   modport source (output valid, output data_byte, output end_of_structure, input ready);
   modport sink   (input valid, input data_byte, input end_of_structure, output ready);
endinterface

@@ hw/rtl/bts_rsp_if.sv @@
// ----------------------------------------------------------------------------
// BER-TLV response channel
// Valid/ready channel carrying the description of one parsed byte.
// ----------------------------------------------------------------------------
interface bts_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  echo_byte;
   logic [1:0]  byte_role;
   logic [23:0] tag_value;
   logic [15:0] value_length;
   logic        is_constructed;
   logic [3:0]  nest_depth;
   logic        header_done;
   logic        reported;
   logic        item_end;
   logic [2:0]  error_code;
   logic        structure_done;

   modport source (
      output valid, output echo_byte, output byte_role, output tag_value,
      output value_length, output is_constructed, output nest_depth,
      output header_done, output reported, output item_end, output error_code,
      output structure_done, input ready
   );
   modport sink (
      input valid, input echo_byte, input byte_role, input tag_value,
      input value_length, input is_constructed, input nest_depth,
      input header_done, input reported, input item_end, input error_code,
      input structure_done, output ready
   );
endinterface

@@ hw/rtl/bts_front.sv @@
// ----------------------------------------------------------------------------
// BER-TLV front end
// Accepts request words, classifies each byte and queues it for the parser.
// ----------------------------------------------------------------------------
module bts_front (
   input  logic                clock,
   input  logic                reset,
   bts_req_if.sink             req_chan,
   output logic                q_valid,
   input  logic                q_ready,
   output bts_pkg::q_word_type q_word
);

   localparam int PW = (bts_pkg::QUEUE_DEPTH > 1) ? $clog2(bts_pkg::QUEUE_DEPTH) : 1;

   bts_pkg::q_word_type queue_ff [bts_pkg::QUEUE_DEPTH];
   bts_pkg::q_word_type word_in;
   logic [PW:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW:0]         rd_ptr_ff, rd_ptr_in;
   logic                full, empty, push, pop;

   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) &&
                  (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);
   assign empty = (wr_ptr_ff == rd_ptr_ff);

   assign req_chan.ready = !full;
   assign push           = req_chan.valid && !full;
   assign q_valid        = !empty;
   assign pop            = q_valid && q_ready;
   assign q_word         = queue_ff[rd_ptr_ff[PW-1:0]];

   always_comb begin
      word_in.data_byte = req_chan.data_byte;
      word_in.last      = req_chan.end_of_structure;
      word_in.tag_more  = (req_chan.data_byte[4:0] == bts_pkg::TAG_MORE_BITS);
      word_in.hi_bit    = req_chan.data_byte[7];
      word_in.cons_bit  = req_chan.data_byte[5];
      word_in.len_long  = (req_chan.data_byte == bts_pkg::LEN_ONE_BYTE) ||
                          (req_chan.data_byte == bts_pkg::LEN_TWO_BYTES);
      wr_ptr_in = push ? wr_ptr_ff + (PW+1)'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + (PW+1)'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff[PW-1:0]] <= word_in;
      end
   end

endmodule

@@ hw/rtl/bts_back.sv @@
// ----------------------------------------------------------------------------
// BER-TLV back end
// Parses one queued byte per cycle against the header, value and container
// state while the result register is free or being taken, and registers the result word.
// ----------------------------------------------------------------------------
module bts_back #(
   parameter int MAX_DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  bts_pkg::q_word_type q_word,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   bts_rsp_if.source           rsp_chan
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_DEPTH);

   bts_pkg::phase_type    phase_ff, phase_in;
   bts_pkg::err_type      err_ff, err_in;
   bts_pkg::err_type      code;
   bts_pkg::role_type     role;
   bts_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [23:0]   tag_ff, tag_in;
   logic          cons_ff, cons_in;
   logic [15:0]   len_ff, len_in;
   logic [1:0]    lbl_ff, lbl_in;
   logic [15:0]   vbl_ff, vbl_in;
   logic [DW-1:0] open_ff, open_in;
   logic          prim_only_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rem_ff [MAX_DEPTH];

   logic [DW-1:0]    top_sum, cand;
   logic [IW-1:0]    top_idx, push_idx;
   logic [15:0]      top_rem, rem_dec, top_wdata;
   logic [16:0]      diff;
   logic [MAX_DEPTH-1:0] zero_vec;
   logic [DW+3:0]    depth_wide;
   logic             top_valid, advance, header, done_len, ignored;
   logic             ie, hd, top_wr, push, failed;

   assign top_valid = (open_ff != '0);
   assign top_sum   = open_ff - DW'(1);
   assign top_idx   = top_sum[IW-1:0];
   assign push_idx  = open_ff[IW-1:0];
   assign top_rem   = rem_ff[top_idx];
   assign rem_dec   = top_rem - 16'd1;

   assign q_ready = !rsp_valid_ff || rsp_chan.ready;
   assign advance = q_valid && q_ready;

   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      tag_in    = tag_ff;
      cons_in   = cons_ff;
      len_in    = len_ff;
      lbl_in    = lbl_ff;
      vbl_in    = vbl_ff;
      open_in   = open_ff;
      code      = bts_pkg::ERR_NONE;
      role      = bts_pkg::ROLE_IGN;
      header    = 1'b0;
      done_len  = 1'b0;
      ignored   = 1'b0;
      ie        = 1'b0;
      hd        = 1'b0;
      top_wr    = 1'b0;
      top_wdata = rem_dec;
      push      = 1'b0;
      cand      = '0;

      unique case (phase_ff)
         bts_pkg::PH_TAG1: begin
            role     = bts_pkg::ROLE_TAG;
            header   = 1'b1;
            tag_in   = {16'h0, q_word.data_byte};
            cons_in  = q_word.cons_bit;
            len_in   = '0;
            phase_in = q_word.tag_more ? bts_pkg::PH_TAG2 : bts_pkg::PH_LEN1;
         end
         bts_pkg::PH_TAG2: begin
            role     = bts_pkg::ROLE_TAG;
            header   = 1'b1;
            tag_in   = {tag_ff[15:0], q_word.data_byte};
            phase_in = q_word.hi_bit ? bts_pkg::PH_TAG3 : bts_pkg::PH_LEN1;
         end
         bts_pkg::PH_TAG3: begin
            role   = bts_pkg::ROLE_TAG;
            header = 1'b1;
            tag_in = {tag_ff[15:0], q_word.data_byte};
            if (q_word.hi_bit) begin
               code = bts_pkg::ERR_BAD_TAG;
            end else begin
               phase_in = bts_pkg::PH_LEN1;
            end
         end
         bts_pkg::PH_LEN1: begin
            role   = bts_pkg::ROLE_LEN;
            header = 1'b1;
            if (!q_word.hi_bit) begin
               len_in   = {8'h0, q_word.data_byte};
               lbl_in   = '0;
               done_len = 1'b1;
            end else if (q_word.len_long) begin
               len_in   = '0;
               lbl_in   = q_word.data_byte[1:0];
               phase_in = bts_pkg::PH_LENX;
            end else begin
               code = bts_pkg::ERR_BAD_LEN;
            end
         end
         bts_pkg::PH_LENX: begin
            role     = bts_pkg::ROLE_LEN;
            header   = 1'b1;
            len_in   = {len_ff[7:0], q_word.data_byte};
            lbl_in   = lbl_ff - 2'd1;
            done_len = (lbl_ff == 2'd1);
         end
         bts_pkg::PH_VALUE: begin
            role   = bts_pkg::ROLE_VAL;
            vbl_in = vbl_ff - 16'd1;
            if (vbl_ff == 16'd1) begin
               ie       = 1'b1;
               phase_in = bts_pkg::PH_TAG1;
            end
         end
         default: begin
            ignored = 1'b1;
         end
      endcase

      diff = {1'b0, top_rem} - {1'b0, len_in} - 17'd1;

      if (header && (code == bts_pkg::ERR_NONE)) begin
         if (top_valid && (top_rem == 16'd0)) begin
            code = bts_pkg::ERR_OVERRUN;
         end else if (done_len) begin
            if (cons_in && (len_in == 16'd0)) begin
               code = bts_pkg::ERR_EMPTY;
            end else if (top_valid && diff[16]) begin
               code = bts_pkg::ERR_OVERRUN;
            end else if (cons_in && (open_ff >= DEPTH_LIMIT)) begin
               code = bts_pkg::ERR_TOO_DEEP;
            end else begin
               hd        = 1'b1;
               top_wr    = top_valid;
               top_wdata = diff[15:0];
               if (cons_in) begin
                  push     = 1'b1;
                  open_in  = open_ff + DW'(1);
                  phase_in = bts_pkg::PH_TAG1;
               end else if (len_in == 16'd0) begin
                  ie       = 1'b1;
                  phase_in = bts_pkg::PH_TAG1;
               end else begin
                  vbl_in   = len_in;
                  phase_in = bts_pkg::PH_VALUE;
               end
            end
         end else begin
            top_wr = top_valid;
            if (top_valid && (rem_dec == 16'd0)) begin
               code = bts_pkg::ERR_OVERRUN;
            end
         end
      end

      // pop every container that has no bytes left, innermost first
      for (int i = 0; i < MAX_DEPTH; i++) begin
         zero_vec[i] = (top_wr && (top_idx == IW'(i))) ? (top_wdata == 16'd0)
                                                         : (rem_ff[i] == 16'd0);
         if ((DW'(i) < open_ff) && !zero_vec[i]) begin
            cand = DW'(i + 1);
         end
      end
      if (ie) begin
         open_in = cand;
      end

      if (q_word.last && !ignored && (code == bts_pkg::ERR_NONE) &&
          !((phase_in == bts_pkg::PH_TAG1) && (open_in == '0))) begin
         code = bts_pkg::ERR_OVERRUN;
      end
      failed = (code != bts_pkg::ERR_NONE);
      if (failed) begin
         phase_in = bts_pkg::PH_ERROR;
         err_in   = code;
      end

      depth_wide = {4'h0, open_ff};
      rsp_in.echo_byte      = q_word.data_byte;
      rsp_in.byte_role      = role;
      rsp_in.tag_value      = ignored ? 24'h0 : tag_in;
      rsp_in.value_length   = (role == bts_pkg::ROLE_LEN || role == bts_pkg::ROLE_VAL) ?
                              len_in : 16'h0;
      rsp_in.is_constructed = !ignored && cons_in;
      rsp_in.nest_depth     = ignored ? 4'h0 : depth_wide[3:0];
      rsp_in.header_done    = hd && !failed;
      rsp_in.reported       = !ignored && (!cons_in || !prim_only_ff);
      rsp_in.item_end       = ie && !failed;
      rsp_in.error_code     = err_in;
      rsp_in.structure_done = q_word.last;

      if (q_word.last) begin
         phase_in = bts_pkg::PH_TAG1;
         err_in   = bts_pkg::ERR_NONE;
         tag_in   = '0;
         cons_in  = 1'b0;
         len_in   = '0;
         lbl_in   = '0;
         vbl_in   = '0;
         open_in  = '0;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bts_pkg::PH_TAG1;
         err_ff       <= bts_pkg::ERR_NONE;
         tag_ff       <= '0;
         cons_ff      <= 1'b0;
         len_ff       <= '0;
         lbl_ff       <= '0;
         vbl_ff       <= '0;
         open_ff      <= '0;
         prim_only_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            err_ff   <= err_in;
            tag_ff   <= tag_in;
            cons_ff  <= cons_in;
            len_ff   <= len_in;
            lbl_ff   <= lbl_in;
            vbl_ff   <= vbl_in;
            open_ff  <= open_in;
         end
         if (csr_wr_en) begin
            prim_only_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < MAX_DEPTH; i++) begin
            if (push && (push_idx == IW'(i))) begin
               rem_ff[i] <= len_in;
            end else if (top_wr && (top_idx == IW'(i))) begin
               rem_ff[i] <= top_wdata;
            end
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.echo_byte      = rsp_ff.echo_byte;
   assign rsp_chan.byte_role      = rsp_ff.byte_role;
   assign rsp_chan.tag_value      = rsp_ff.tag_value;
   assign rsp_chan.value_length   = rsp_ff.value_length;
   assign rsp_chan.is_constructed = rsp_ff.is_constructed;
   assign rsp_chan.nest_depth     = rsp_ff.nest_depth;
   assign rsp_chan.header_done    = rsp_ff.header_done;
   assign rsp_chan.reported       = rsp_ff.reported;
   assign rsp_chan.item_end       = rsp_ff.item_end;
   assign rsp_chan.error_code     = rsp_ff.error_code;
   assign rsp_chan.structure_done = rsp_ff.structure_done;

endmodule

@@ hw/rtl/ber_tlv_stream_parser_top.sv @@
// A request word is written into the queue, then parsed into the result register on rsp.
// The back end parses one word per cycle while its result register is free or being taken.
// A two-word queue between front and back lets each side stall on its own.
// Reset (synchronous, active high) empties the queue and the result register,
// returns the parser to the first tag byte and clears primitive_only.
// ----------------------------------------------------------------------------
// BER-TLV stream parser top level
// Byte-serial BER-TLV parser: classifying front end, queue, parsing back end.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_top #(
   parameter int MAX_DEPTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   bts_req_if.sink   req_chan,
   bts_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   logic                q_valid;
   logic                q_ready;
   bts_pkg::q_word_type q_word;

   bts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_word   (q_word)
   );

   bts_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_word      (q_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ hw/rtl/bts_checker.sv @@
// ----------------------------------------------------------------------------
// BER-TLV port checker
// Watches the response port of the parser top level.
// ----------------------------------------------------------------------------
module bts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  echo_byte,
   input logic [1:0]  byte_role,
   input logic [23:0] tag_value,
   input logic [15:0] value_length,
   input logic [3:0]  nest_depth,
   input logic        header_done,
   input logic        item_end,
   input logic [2:0]  error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(echo_byte) &&
      $stable(tag_value) && $stable(error_code))
      else $error("stalled response word changed");

   a_ign_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (byte_role == bts_pkg::ROLE_IGN) |->
      (error_code != bts_pkg::ERR_NONE) && (tag_value == 24'h0) && (nest_depth == 4'h0))
      else $error("ignored word without error or with fields");

   a_tag_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (byte_role == bts_pkg::ROLE_TAG) |->
      (value_length == 16'h0) && !header_done && !item_end)
      else $error("tag word carries length or end marks");

   a_hdr_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && header_done |->
      (byte_role == bts_pkg::ROLE_LEN) && (error_code == bts_pkg::ERR_NONE))
      else $error("header done on a non-length or failing word");

endmodule

bind ber_tlv_stream_parser_top bts_checker u_bts_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .echo_byte    (rsp_chan.echo_byte),
   .byte_role    (rsp_chan.byte_role),
   .tag_value    (rsp_chan.tag_value),
   .value_length (rsp_chan.value_length),
   .nest_depth   (rsp_chan.nest_depth),
   .header_done  (rsp_chan.header_done),
   .item_end     (rsp_chan.item_end),
   .error_code   (rsp_chan.error_code)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// BER-TLV stream parser testbench
// Drives directed and random TLV byte streams through the parser, predicts the
// description word of every byte with a local parser copy, and compares each
// returned word field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_NEST    = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   bts_req_if req_bus ();
   bts_rsp_if rsp_bus ();

   ber_tlv_stream_parser_top #(.MAX_DEPTH(MAX_NEST)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // parser copy
   logic                 prim_only;
   bts_pkg::phase_type   cur_phase;
   logic [23:0]          tag_acc;
   logic [1:0]           tag_count;
   logic [15:0]          len_acc;
   logic [1:0]           len_left;
   logic [15:0]          value_left;
   logic [15:0]          level_left [MAX_NEST];
   logic [3:0]           open_count;
   bts_pkg::err_type     held_err;

   bts_pkg::rsp_word_type byte_desc_q [$];
   bts_pkg::rsp_word_type oldest;
   int           error_count  = 0;
   int           parsed_count = 0;
   int           cycle_count  = 0;
   int           hold_cycles  = 0;
   bit           src_idle     = 1'b1;
   bit           snk_idle     = 1'b1;

   logic [7:0] frame [$];
   logic [7:0] hdr [$];
   int         item_start [$];
   int         item_nest [$];

   function automatic void clear_parse_state();
      cur_phase  = bts_pkg::PH_TAG1;
      tag_acc    = '0;
      tag_count  = '0;
      len_acc    = '0;
      len_left   = '0;
      value_left = '0;
      open_count = '0;
      held_err   = bts_pkg::ERR_NONE;
      for (int k = 0; k < MAX_NEST; k++) level_left[k] = '0;
   endfunction

   function automatic void set_error(bts_pkg::err_type code);
      held_err  = code;
      cur_phase = bts_pkg::PH_ERROR;
   endfunction

   function automatic logic in_container();
      return open_count != 0 && open_count <= MAX_NEST;
   endfunction

   function automatic logic take_header_byte();
      if (!in_container()) return 1'b1;
      if (level_left[open_count - 1] == 0) return 1'b0;
      level_left[open_count - 1] = level_left[open_count - 1] - 16'd1;
      return 1'b1;
   endfunction

   function automatic logic tag_is_cons();
      case (tag_count)
         2'd1: return tag_acc[5];
         2'd2: return tag_acc[13];
         2'd3: return tag_acc[21];
         default: return 1'b0;
      endcase
   endfunction

   // returns the item end of a zero-length primitive
   function automatic logic close_header(output logic hdr_done);
      logic        cons;
      logic [15:0] len;
      len      = len_acc;
      cons     = tag_is_cons();
      hdr_done = 1'b0;
      if (cons && len == 0) begin
         set_error(bts_pkg::ERR_EMPTY);
         return 1'b0;
      end
      if (in_container() && len > level_left[open_count - 1]) begin
         set_error(bts_pkg::ERR_OVERRUN);
         return 1'b0;
      end
      if (cons && open_count >= MAX_NEST) begin
         set_error(bts_pkg::ERR_TOO_DEEP);
         return 1'b0;
      end
      if (in_container()) level_left[open_count - 1] = level_left[open_count - 1] - len;
      hdr_done = 1'b1;
      if (cons) begin
         level_left[open_count] = len;
         open_count = open_count + 4'd1;
         cur_phase  = bts_pkg::PH_TAG1;
         return 1'b0;
      end
      if (len == 0) begin
         cur_phase = bts_pkg::PH_TAG1;
         return 1'b1;
      end
      value_left = len;
      cur_phase  = bts_pkg::PH_VALUE;
      return 1'b0;
   endfunction

   function automatic bts_pkg::rsp_word_type parse_byte(logic [7:0] b, logic last);
      bts_pkg::role_type     role;
      logic [3:0]            depth;
      logic [15:0]           vlen;
      logic                  hd, ie, ignored, in_header, cons;
      bts_pkg::rsp_word_type word;
      role      = bts_pkg::ROLE_IGN;
      depth     = open_count;
      vlen      = '0;
      hd        = 1'b0;
      ie        = 1'b0;
      ignored   = 1'b0;
      in_header = 1'b0;
      case (cur_phase)
         bts_pkg::PH_TAG1: begin
            role      = bts_pkg::ROLE_TAG;
            in_header = 1'b1;
            tag_acc   = {16'h0, b};
            tag_count = 2'd1;
            len_acc   = '0;
            cur_phase = (b[4:0] == bts_pkg::TAG_MORE_BITS) ? bts_pkg::PH_TAG2
                                                            : bts_pkg::PH_LEN1;
         end
         bts_pkg::PH_TAG2: begin
            role      = bts_pkg::ROLE_TAG;
            in_header = 1'b1;
            tag_acc   = {tag_acc[15:0], b};
            tag_count = 2'd2;
            cur_phase = b[7] ? bts_pkg::PH_TAG3 : bts_pkg::PH_LEN1;
         end
         bts_pkg::PH_TAG3: begin
            role      = bts_pkg::ROLE_TAG;
            in_header = 1'b1;
            tag_acc   = {tag_acc[15:0], b};
            tag_count = 2'd3;
            if (b[7]) set_error(bts_pkg::ERR_BAD_TAG);
            else cur_phase = bts_pkg::PH_LEN1;
         end
         bts_pkg::PH_LEN1: begin
            role      = bts_pkg::ROLE_LEN;
            in_header = 1'b1;
            if (!b[7]) begin
               len_acc  = {8'h0, b};
               len_left = '0;
            end else if (b == bts_pkg::LEN_ONE_BYTE || b == bts_pkg::LEN_TWO_BYTES) begin
               len_acc   = '0;
               len_left  = b[1:0];
               cur_phase = bts_pkg::PH_LENX;
            end else begin
               set_error(bts_pkg::ERR_BAD_LEN);
            end
         end
         bts_pkg::PH_LENX: begin
            role      = bts_pkg::ROLE_LEN;
            in_header = 1'b1;
            len_acc   = {len_acc[7:0], b};
            len_left  = len_left - 2'd1;
         end
         bts_pkg::PH_VALUE: begin
            role       = bts_pkg::ROLE_VAL;
            value_left = value_left - 16'd1;
            if (value_left == 0) begin
               ie        = 1'b1;
               cur_phase = bts_pkg::PH_TAG1;
            end
         end
         default: ignored = 1'b1;
      endcase

      if (in_header && cur_phase != bts_pkg::PH_ERROR) begin
         if (!take_header_byte())
            set_error(bts_pkg::ERR_OVERRUN);
         else if (role == bts_pkg::ROLE_LEN && (cur_phase == bts_pkg::PH_LEN1 ||
                  (cur_phase == bts_pkg::PH_LENX && len_left == 0)))
            ie = close_header(hd);
         else if (in_container() && level_left[open_count - 1] == 0)
            set_error(bts_pkg::ERR_OVERRUN);
      end
      if (ie) begin
         while (in_container() && level_left[open_count - 1] == 0)
            open_count = open_count - 4'd1;
      end
      if (role == bts_pkg::ROLE_LEN || role == bts_pkg::ROLE_VAL) vlen = len_acc;
      if (last && cur_phase != bts_pkg::PH_ERROR &&
          !(cur_phase == bts_pkg::PH_TAG1 && open_count == 0))
         set_error(bts_pkg::ERR_OVERRUN);
      if (cur_phase == bts_pkg::PH_ERROR) begin
         hd = 1'b0;
         ie = 1'b0;
      end

      word                = '0;
      word.echo_byte      = b;
      word.byte_role      = role;
      word.error_code     = held_err;
      word.structure_done = last;
      if (!ignored) begin
         cons                = tag_is_cons();
         word.tag_value      = tag_acc;
         word.value_length   = vlen;
         word.is_constructed = cons;
         word.nest_depth     = depth;
         word.header_done    = hd;
         word.reported       = !cons || !prim_only;
         word.item_end       = ie;
      end
      if (last) clear_parse_state();
      return word;
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (byte_desc_q.size() == 0) begin
            error_count++;
            $display("%0t: word expected none actual echo_byte %0h", $time,
                     rsp_bus.echo_byte);
         end else begin
            oldest = byte_desc_q.pop_front();
            check_field("echo_byte", oldest.echo_byte, rsp_bus.echo_byte);
            check_field("byte_role", oldest.byte_role, rsp_bus.byte_role);
            check_field("tag_value", oldest.tag_value, rsp_bus.tag_value);
            check_field("value_length", oldest.value_length, rsp_bus.value_length);
            check_field("is_constructed", oldest.is_constructed, rsp_bus.is_constructed);
            check_field("nest_depth", oldest.nest_depth, rsp_bus.nest_depth);
            check_field("header_done", oldest.header_done, rsp_bus.header_done);
            check_field("reported", oldest.reported, rsp_bus.reported);
            check_field("item_end", oldest.item_end, rsp_bus.item_end);
            check_field("error_code", oldest.error_code, rsp_bus.error_code);
            check_field("structure_done", oldest.structure_done, rsp_bus.structure_done);
         end
      end
   end

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = snk_idle ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      bts_pkg::rsp_word_type want;
      gap = src_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.data_byte        <= b;
      req_bus.end_of_structure <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = parse_byte(b, last);
      if (want.byte_role != bts_pkg::ROLE_IGN) parsed_count++;
      byte_desc_q.push_back(want);
   endtask

   task automatic send_frame();
      for (int k = 0; k < frame.size(); k++) send_byte(frame[k], k == frame.size() - 1);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (byte_desc_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_prim_only(logic v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      prim_only = v;
   endtask

   function automatic void build_header(logic cons, int len);
      logic [7:0] t;
      int tag_bytes, form;
      hdr       = {};
      tag_bytes = $urandom_range(1, 3);
      t         = 8'($urandom);
      t[5]      = cons;
      if (tag_bytes == 1) begin
         if (t[4:0] == bts_pkg::TAG_MORE_BITS) t[0] = 1'b0;
         hdr.push_back(t);
      end else begin
         t[4:0] = bts_pkg::TAG_MORE_BITS;
         hdr.push_back(t);
         t    = 8'($urandom);
         t[7] = (tag_bytes == 3);
         hdr.push_back(t);
         if (tag_bytes == 3) begin
            t    = 8'($urandom);
            t[7] = 1'b0;
            hdr.push_back(t);
         end
      end
      form = $urandom_range(0, 3);
      if (len < 128 && form < 2) begin
         hdr.push_back(8'(len));
      end else if (len < 256 && form < 3) begin
         hdr.push_back(bts_pkg::LEN_ONE_BYTE);
         hdr.push_back(8'(len));
      end else begin
         hdr.push_back(bts_pkg::LEN_TWO_BYTES);
         hdr.push_back(8'(len >> 8));
         hdr.push_back(8'(len));
      end
   endfunction

   // build random primitive items, then wrap random runs of items into constructed items
   function automatic void build_structure();
      int n_items, n_wraps, i, j, span, len, stop, deepest;
      frame      = {};
      item_start = {};
      item_nest  = {};
      n_items    = $urandom_range(1, 6);
      repeat (n_items) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 6);
         build_header(1'b0, len);
         item_start.push_back(frame.size());
         item_nest.push_back(0);
         foreach (hdr[k]) frame.push_back(hdr[k]);
         repeat (len) frame.push_back(8'($urandom));
      end
      n_wraps = $urandom_range(0, 10);
      repeat (n_wraps) begin
         i    = $urandom_range(0, item_start.size() - 1);
         span = $urandom_range(1, 3);
         if (span > item_start.size() - i) span = item_start.size() - i;
         j       = i + span - 1;
         stop    = (j + 1 < item_start.size()) ? item_start[j + 1] : frame.size();
         len     = stop - item_start[i];
         deepest = 0;
         for (int k = i; k <= j; k++) if (item_nest[k] > deepest) deepest = item_nest[k];
         build_header(1'b1, len);
         for (int k = hdr.size() - 1; k >= 0; k--) frame.insert(item_start[i], hdr[k]);
         for (int k = j + 1; k < item_start.size(); k++)
            item_start[k] = item_start[k] + hdr.size();
         item_nest[i] = deepest + 1;
         for (int k = j; k > i; k--) begin
            item_start.delete(k);
            item_nest.delete(k);
         end
      end
   endfunction

   function automatic void damage_structure();
      int mode, cut;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
      end else if (mode == 1) begin
         cut = $urandom_range(1, frame.size());
         while (frame.size() > cut) void'(frame.pop_back());
      end else if (mode == 2) begin
         frame = {};
         repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
      end
   endfunction

   task automatic test_single_items();
      frame = '{8'h5A, 8'h01, 8'hFF};
      send_frame();
      frame = '{8'h00, 8'h01, 8'h00};
      send_frame();
      frame = '{8'hDF, 8'hFF, 8'h7F, 8'h00};
      send_frame();
      frame = '{8'h04, 8'h82, 8'h00, 8'h01, 8'h80};
      send_frame();
      frame = '{8'hBF, 8'h9F, 8'h01, 8'h81, 8'h02, 8'hC1, 8'h00};
      send_frame();
   endtask

   task automatic test_error_codes();
      frame = '{8'h1F, 8'h80, 8'h80, 8'h55};
      send_frame();
      frame = '{8'h01, 8'h83, 8'h00};
      send_frame();
      frame = '{8'h20, 8'h00};
      send_frame();
      frame = '{8'h30, 8'h02, 8'h01, 8'h05, 8'hAA};
      send_frame();
      frame = '{8'h30, 8'h01, 8'h01};
      send_frame();
      frame = '{8'h20, 8'h05, 8'h01, 8'h00};
      send_frame();
      frame = '{8'h1F, 8'h7F, 8'h82, 8'hFF, 8'hFF};
      send_frame();
      frame = '{8'h01, 8'h02, 8'hAA};
      send_frame();
   endtask

   task automatic test_nesting_limit();
      frame = {};
      for (int k = 0; k <= MAX_NEST; k++) begin
         frame.push_back(8'h20);
         frame.push_back(8'(17 - 2 * k));
      end
      frame.push_back(8'h00);
      send_frame();
   endtask

   task automatic test_primitive_only();
      write_prim_only(1'b1);
      frame = '{8'hBF, 8'h9F, 8'h01, 8'h81, 8'h02, 8'hC1, 8'h00};
      send_frame();
      frame = '{8'h30, 8'h03, 8'h01, 8'h01, 8'hEE};
      send_frame();
      write_prim_only(1'b0);
   endtask

   task automatic test_receiver_hold();
      wait_idle();
      src_idle    = 1'b0;
      hold_cycles = 150;
      frame       = '{8'h04, 8'h81, 8'd40};
      repeat (40) frame.push_back(8'($urandom));
      send_frame();
      wait_idle();
      src_idle = 1'b1;
   endtask

   task automatic test_random_structures();
      int goal;
      for (int round = 0; round < 3; round++) begin
         write_prim_only(round == 0 ? 1'b1 : (round == 1 ? 1'b0 : 1'($urandom)));
         goal = parsed_count + 150;
         while (parsed_count < goal) begin
            build_structure();
            damage_structure();
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            send_frame();
         end
      end
      src_idle = 1'b1;
      snk_idle = 1'b1;
   endtask

   initial begin
      reset                    <= 1'b1;
      csr_wr_en                <= 1'b0;
      csr_wr_data              <= 1'b0;
      req_bus.valid            <= 1'b0;
      req_bus.data_byte        <= 8'h00;
      req_bus.end_of_structure <= 1'b0;
      prim_only = 1'b0;
      clear_parse_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_single_items();
      test_error_codes();
      test_nesting_limit();
      test_primitive_only();
      test_receiver_hold();
      test_random_structures();
      wait_idle();

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/bts_pkg.sv
hw/rtl/bts_req_if.sv
hw/rtl/bts_rsp_if.sv
hw/rtl/bts_front.sv
hw/rtl/bts_back.sv
hw/rtl/ber_tlv_stream_parser_top.sv
hw/rtl/bts_checker.sv
tb/testbench.sv
